// ===== src/elt_pkg.sv =====
// Shared types and constants for the expression language tokenizer.
// Depends on nothing; imported by the scanner, the token queue and the top level.
package elt_pkg;

  localparam int POS_BITS = 16;
  localparam int OUT_W    = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_DOT     = 3'd2;
  localparam logic [2:0] M_INT     = 3'd3;
  localparam logic [2:0] M_FRAC    = 3'd4;
  localparam logic [2:0] M_IDENT   = 3'd5;
  localparam logic [2:0] M_COMMENT = 3'd6;

  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_PLUS   = 4'd1;
  localparam logic [3:0] K_MINUS  = 4'd2;
  localparam logic [3:0] K_STAR   = 4'd3;
  localparam logic [3:0] K_SLASH  = 4'd4;
  localparam logic [3:0] K_SEMI   = 4'd5;
  localparam logic [3:0] K_LPAREN = 4'd6;
  localparam logic [3:0] K_RPAREN = 4'd7;
  localparam logic [3:0] K_NUMBER = 4'd8;
  localparam logic [3:0] K_IDENT  = 4'd9;
  localparam logic [3:0] K_PRINT  = 4'd10;
  localparam logic [3:0] K_TRUE   = 4'd11;
  localparam logic [3:0] K_FALSE  = 4'd12;
  localparam logic [3:0] K_ERROR  = 4'd13;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam int NUM_KW = 3;
  localparam logic [0:NUM_KW-1][0:3][7:0] KW_REST = {"rint", "rue", 8'h00, "alse"};
  localparam logic [0:NUM_KW-1][2:0]      KW_LEN  = {3'd4, 3'd3, 3'd4};
  localparam logic [0:NUM_KW-1][3:0]      KW_KIND = {K_PRINT, K_TRUE, K_FALSE};

  typedef struct packed {
    logic [3:0]       kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic [OUT_W-1:0] line;
    logic             last;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tq_wr_t;

endpackage

// ===== src/elt_scan.sv =====
// Front end: classifies one byte per cycle while take is high; forms up to two tokens.
// Depends on elt_pkg; feeds the token queue through a tq_wr_t bundle.
module elt_scan import elt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_in,
  output tq_wr_t     wr
);

  logic [2:0]          mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] beg_r, beg_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [NUM_KW-1:0]   hits_r, hits_nxt;

  logic [POS_BITS-1:0] pos_adv, tok_len, len_m1;
  logic [1:0]          kw_idx;
  logic                to_idle, is_dig, is_alp;
  logic [3:0]          id_kind, op_kind;
  logic [NUM_KW-1:0]   keep;

  function automatic tok_t mk_tok(input logic [3:0] kind,
                                  input logic [POS_BITS-1:0] start,
                                  input logic [POS_BITS-1:0] len,
                                  input logic [POS_BITS-1:0] line);
    tok_t t;
    t.kind   = kind;
    t.start  = OUT_W'(start);
    t.length = OUT_W'(len);
    t.line   = OUT_W'(line);
    t.last   = 1'b1;
    return t;
  endfunction

  always_comb begin
    pos_adv = (pos_r == POS_MAX) ? pos_r : pos_r + POS_BITS'(1);
    tok_len = pos_r - beg_r;
    len_m1  = tok_len - POS_BITS'(1);
    kw_idx  = len_m1[1:0];
    is_dig  = (char_in >= "0") && (char_in <= "9");
    is_alp  = ((char_in >= "a") && (char_in <= "z")) ||
              ((char_in >= "A") && (char_in <= "Z"));
    for (int k = 0; k < NUM_KW; k++) begin
      keep[k] = (tok_len != '0) && (tok_len <= POS_BITS'(KW_LEN[k])) &&
                (KW_REST[k][kw_idx] == char_in);
    end
    id_kind = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (hits_r[k] && (tok_len == POS_BITS'(KW_LEN[k]) + POS_BITS'(1))) begin
        id_kind = KW_KIND[k];
      end
    end
    case (char_in)
      CH_PLUS:  op_kind = K_PLUS;
      CH_MINUS: op_kind = K_MINUS;
      CH_STAR:  op_kind = K_STAR;
      CH_SEMI:  op_kind = K_SEMI;
      CH_LPAR:  op_kind = K_LPAREN;
      CH_RPAR:  op_kind = K_RPAREN;
      default:  op_kind = K_ERROR;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    line_nxt = line_r;
    hits_nxt = hits_r;
    to_idle  = 1'b0;
    wr       = '0;
    if (take) begin
      case (mode_r)
        M_COMMENT: begin
          if ((char_in == CH_LF) || (char_in == CH_NUL)) to_idle = 1'b1;
          else pos_nxt = pos_adv;
        end
        M_SLASH: begin
          if (char_in == CH_SLASH) begin
            mode_nxt = M_COMMENT;
            pos_nxt  = pos_adv;
          end else begin
            wr.v0   = 1'b1;
            wr.t0   = mk_tok(K_SLASH, beg_r, POS_BITS'(1), line_r);
            to_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (is_dig) begin
            mode_nxt = M_FRAC;
            pos_nxt  = pos_adv;
          end else begin
            wr.v0   = 1'b1;
            wr.t0   = mk_tok(K_ERROR, beg_r, POS_BITS'(1), line_r);
            to_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_dig) begin
            pos_nxt = pos_adv;
          end else if (char_in == CH_DOT) begin
            mode_nxt = M_FRAC;
            pos_nxt  = pos_adv;
          end else begin
            wr.v0   = 1'b1;
            wr.t0   = mk_tok(K_NUMBER, beg_r, tok_len, line_r);
            to_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_dig) begin
            pos_nxt = pos_adv;
          end else begin
            wr.v0   = 1'b1;
            wr.t0   = mk_tok(K_NUMBER, beg_r, tok_len, line_r);
            to_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alp) begin
            hits_nxt = (pos_r == POS_MAX) ? '0 : (hits_r & keep);
            pos_nxt  = pos_adv;
          end else begin
            wr.v0   = 1'b1;
            wr.t0   = mk_tok(id_kind, beg_r, tok_len, line_r);
            to_idle = 1'b1;
          end
        end
        default: to_idle = 1'b1;
      endcase

      if (to_idle) begin
        mode_nxt = M_IDLE;
        if (char_in == CH_NUL) begin
          wr.v1    = 1'b1;
          wr.t1    = mk_tok(K_EOF, '0, '0, line_r);
          pos_nxt  = '0;
          beg_nxt  = '0;
          line_nxt = POS_BITS'(1);
          hits_nxt = '1;
        end else if (char_in == CH_LF) begin
          line_nxt = (line_r == POS_MAX) ? line_r : line_r + POS_BITS'(1);
          pos_nxt  = pos_adv;
        end else if ((char_in == CH_SPACE) || (char_in == CH_TAB) ||
                     (char_in == CH_CR)) begin
          pos_nxt = pos_adv;
        end else if (char_in == CH_SLASH) begin
          beg_nxt  = pos_r;
          mode_nxt = M_SLASH;
          pos_nxt  = pos_adv;
        end else if (char_in == CH_DOT) begin
          beg_nxt  = pos_r;
          mode_nxt = M_DOT;
          pos_nxt  = pos_adv;
        end else if (is_dig) begin
          beg_nxt  = pos_r;
          mode_nxt = M_INT;
          pos_nxt  = pos_adv;
        end else if (is_alp) begin
          beg_nxt  = pos_r;
          mode_nxt = M_IDENT;
          pos_nxt  = pos_adv;
          if (pos_r == POS_MAX)       hits_nxt = '0;
          else if (char_in == CH_P)   hits_nxt = 3'b001;
          else if (char_in == CH_T)   hits_nxt = 3'b010;
          else if (char_in == CH_F)   hits_nxt = 3'b100;
          else                        hits_nxt = '0;
        end else begin
          beg_nxt = pos_r;
          wr.v1   = 1'b1;
          wr.t1   = mk_tok(op_kind, pos_r, POS_BITS'(1), line_r);
          pos_nxt = pos_adv;
        end
      end
      wr.t0.last = ~wr.v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      beg_r  <= '0;
      line_r <= POS_BITS'(1);
      hits_r <= '1;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      line_r <= line_nxt;
      hits_r <= hits_nxt;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_pos_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (mode_r == M_IDLE) && (char_in == CH_NUL)) |=> (pos_r == '0))
    else $error("position not cleared after end of text");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= M_COMMENT)
    else $error("scan mode outside the known codes");

endmodule

// ===== src/elt_tokq.sv =====
// Back end: small token queue taking up to two tokens a cycle, handing out one per pop.
// Depends on elt_pkg for tok_t, tq_wr_t and the queue depth.
module elt_tokq import elt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  tq_wr_t wr,
  input  logic   pop,
  output tok_t   head,
  output logic   empty,
  output logic   full
);

  tok_t mem [TQ_DEPTH];

  logic [TQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [TQ_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]       n_wr;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r > TQ_CW'(TQ_DEPTH - 2));
  assign head   = mem[rp_r];
  assign do_pop = pop && !empty;
  assign n_wr   = 2'(wr.v0) + 2'(wr.v1);

  always_comb begin
    wp_nxt  = wp_r + TQ_AW'(n_wr);
    rp_nxt  = rp_r + TQ_AW'(do_pop);
    cnt_nxt = cnt_r + TQ_CW'(n_wr) - TQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (wr.v0 && wr.v1) begin
      mem[wp_r]                  <= wr.t0;
      mem[wp_r + TQ_AW'(1)]      <= wr.t1;
    end else if (wr.v0) begin
      mem[wp_r] <= wr.t0;
    end else if (wr.v1) begin
      mem[wp_r] <= wr.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.v0 || wr.v1) |-> (cnt_r <= TQ_CW'(TQ_DEPTH - 2)))
    else $error("token written into a queue without room for two");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= TQ_CW'(TQ_DEPTH))
    else $error("token queue count beyond depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (cnt_r == '0) && (wp_r == rp_r))
    else $error("token queue not empty after reset");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wp_r == rp_r))
    else $error("pointers disagree on an empty queue");

endmodule

// ===== src/expression_language_tokenizer.sv =====
// Top level of the expression language tokenizer: byte scanner plus token queue.
// Depends on elt_pkg, elt_scan and elt_tokq.
//
//   channel  | handshake       | payload
//   ---------+-----------------+--------------------------------------------------
//   in       | push / full     | in_char_in
//   out      | empty / pop     | out_token_kind, out_token_start, out_token_length,
//            |                 | out_token_line, out_last_of_run
//
// Unless full, one text byte is taken per cycle; its tokens (none, one or two)
// enter the queue in that cycle; the oldest is on the out ports the cycle after.
// The out port hands out one token per cycle while pop is high and empty is low,
// so a byte that closes one token and is itself a one-byte token needs two pops.
// full rises when the four-entry token queue has fewer than two free slots.
// Reset is synchronous: queue empty, line one, position zero.
module expression_language_tokenizer import elt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_char_in,
  output logic             empty,
  input  logic             pop,
  output logic [3:0]       out_token_kind,
  output logic [OUT_W-1:0] out_token_start,
  output logic [OUT_W-1:0] out_token_length,
  output logic [OUT_W-1:0] out_token_line,
  output logic             out_last_of_run
);

  tq_wr_t wr;
  tok_t   head;
  logic   take;

  assign take = push && !full;

  elt_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .char_in (in_char_in),
    .wr      (wr)
  );

  elt_tokq u_tokq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_token_line   = head.line;
  assign out_last_of_run  = head.last;

endmodule

// ===== tb/sv/tb_expression_language_tokenizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the expression language tokenizer: it streams text
// bytes, predicts every token with a scanner model of its own and checks each popped
// transaction. Depends on elt_pkg and expression_language_tokenizer.
module tb_expression_language_tokenizer;
  import elt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 585;
  localparam int MAX_REPORTS  = 40;

  localparam logic [0:2][0:3][7:0] KW_TAIL  = {"rint", "rue.", "alse"};
  localparam logic [0:2][2:0]      KW_SIZE  = {3'd4, 3'd3, 3'd4};
  localparam logic [0:2][3:0]      KW_TOKEN = {K_PRINT, K_TRUE, K_FALSE};

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic [7:0]       in_char_in;
  logic             empty;
  logic             pop;
  logic [3:0]       out_token_kind;
  logic [OUT_W-1:0] out_token_start;
  logic [OUT_W-1:0] out_token_length;
  logic [OUT_W-1:0] out_token_line;
  logic             out_last_of_run;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_reqs;
  int          fail_cnt;
  int          checked_cnt;
  int unsigned sent_cnt;
  int          cycle_cnt;
  tok_t        pending_tokens[$];

  logic [2:0]          scan_st;
  logic [POS_BITS-1:0] pos_q;
  logic [POS_BITS-1:0] begin_q;
  logic [POS_BITS-1:0] line_q;
  logic [2:0]          kw_q;

  expression_language_tokenizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_in       (in_char_in),
    .empty            (empty),
    .pop              (pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_line   (out_token_line),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_scanner();
    scan_st = M_IDLE;
    pos_q   = '0;
    begin_q = '0;
    line_q  = POS_BITS'(1);
    kw_q    = 3'b111;
  endfunction

  function automatic void bump_pos();
    if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
  endfunction

  function automatic void open_token(input logic [2:0] mode);
    begin_q = pos_q;
    scan_st = mode;
    bump_pos();
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic tok_t token_of(input logic [3:0] kind, input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS-1:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.line   = line_q;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] ident_token(input logic [POS_BITS-1:0] len);
    for (int k = 0; k < 3; k++)
      if (kw_q[k] && len == KW_SIZE[k] + 1) return KW_TOKEN[k];
    return K_IDENT;
  endfunction

  function automatic void tokenise_byte(input logic [7:0] c);
    tok_t                made[$];
    logic [POS_BITS-1:0] p;
    logic [POS_BITS-1:0] off;
    logic [1:0]          ci;
    logic [3:0]          kind;
    bit                  redo;
    redo = 1'b1;
    while (redo) begin
      p    = pos_q;
      off  = p - begin_q;
      redo = 1'b0;
      case (scan_st)
        M_COMMENT: begin
          if (c == CH_LF || c == CH_NUL) begin
            scan_st = M_IDLE;
            redo    = 1'b1;
          end else begin
            bump_pos();
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            scan_st = M_COMMENT;
            bump_pos();
          end else begin
            made.push_back(token_of(K_SLASH, begin_q, POS_BITS'(1)));
            scan_st = M_IDLE;
            redo    = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            scan_st = M_FRAC;
            bump_pos();
          end else begin
            made.push_back(token_of(K_ERROR, begin_q, POS_BITS'(1)));
            scan_st = M_IDLE;
            redo    = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            bump_pos();
          end else if (c == CH_DOT) begin
            scan_st = M_FRAC;
            bump_pos();
          end else begin
            made.push_back(token_of(K_NUMBER, begin_q, off));
            scan_st = M_IDLE;
            redo    = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            bump_pos();
          end else begin
            made.push_back(token_of(K_NUMBER, begin_q, off));
            scan_st = M_IDLE;
            redo    = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c)) begin
            ci = off[1:0] - 2'd1;
            for (int k = 0; k < 3; k++)
              if (off < 1 || off > KW_SIZE[k] || KW_TAIL[k][ci] != c) kw_q[k] = 1'b0;
            if (p == POS_MAX) kw_q = '0;
            bump_pos();
          end else begin
            made.push_back(token_of(ident_token(off), begin_q, off));
            scan_st = M_IDLE;
            redo    = 1'b1;
          end
        end
        default: begin
          scan_st = M_IDLE;
          if (c == CH_NUL) begin
            made.push_back(token_of(K_EOF, '0, '0));
            clear_scanner();
          end else if (c == CH_LF) begin
            if (line_q != POS_MAX) line_q = line_q + 1'b1;
            bump_pos();
          end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            bump_pos();
          end else if (c == CH_SLASH) begin
            open_token(M_SLASH);
          end else if (c == CH_DOT) begin
            open_token(M_DOT);
          end else if (is_digit(c)) begin
            open_token(M_INT);
          end else if (is_alpha(c)) begin
            kw_q = (c == CH_P) ? 3'b001 : (c == CH_T) ? 3'b010 : (c == CH_F) ? 3'b100 : 3'b000;
            open_token(M_IDENT);
            if (p == POS_MAX) kw_q = '0;
          end else begin
            case (c)
              CH_PLUS:  kind = K_PLUS;
              CH_MINUS: kind = K_MINUS;
              CH_STAR:  kind = K_STAR;
              CH_SEMI:  kind = K_SEMI;
              CH_LPAR:  kind = K_LPAREN;
              CH_RPAR:  kind = K_RPAREN;
              default:  kind = K_ERROR;
            endcase
            begin_q = p;
            made.push_back(token_of(kind, p, POS_BITS'(1)));
            bump_pos();
          end
        end
      endcase
    end
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) pending_tokens.push_back(made[i]);
  endfunction

  function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (rst_n && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $error("token_kind: expected no token, got %0d", out_token_kind);
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", OUT_W'(want.kind), OUT_W'(out_token_kind));
        check_field("token_start", want.start, out_token_start);
        check_field("token_length", want.length, out_token_length);
        check_field("token_line", want.line, out_token_line);
        check_field("last_of_run", OUT_W'(want.last), OUT_W'(out_last_of_run));
        checked_cnt++;
      end
    end
  end

  initial begin : drain_tokens
    int          held;
    int unsigned holds_done;
    holds_done = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        pop <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    tokenise_byte(c);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic string pick_word();
    case ($urandom_range(0, 8))
      0:       return "print";
      1:       return "true";
      2:       return "false";
      3:       return "prin";
      4:       return "trues";
      5:       return "fals";
      6:       return "Print";
      7:       return "tr";
      default: return "falsehood";
    endcase
  endfunction

  task automatic send_fragment();
    int n;
    case ($urandom_range(0, 15))
      0, 1: begin
        case ($urandom_range(0, 6))
          0:       send_byte(CH_PLUS);
          1:       send_byte(CH_MINUS);
          2:       send_byte(CH_STAR);
          3:       send_byte(CH_SLASH);
          4:       send_byte(CH_SEMI);
          5:       send_byte(CH_LPAR);
          default: send_byte(CH_RPAR);
        endcase
      end
      2, 3: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'("0" + $urandom_range(9)));
        if ($urandom_range(1)) begin
          send_byte(CH_DOT);
          n = $urandom_range(0, 3);
          repeat (n) send_byte(8'("0" + $urandom_range(9)));
        end
      end
      4: begin
        send_byte(CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(8'("0" + $urandom_range(9)));
      end
      5, 6: begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)));
      end
      7: send_text(pick_word());
      8, 9: begin
        case ($urandom_range(0, 3))
          0:       send_byte(CH_TAB);
          1:       send_byte(CH_CR);
          2:       send_byte(CH_LF);
          default: send_byte(CH_SPACE);
        endcase
      end
      10: begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        n = $urandom_range(0, 8);
        repeat (n) send_byte(8'($urandom_range(1, 255)));
        if ($urandom_range(3) != 0) send_byte(CH_LF);
      end
      11: send_byte(8'($urandom_range(1, 255)));
      12: send_byte(CH_NUL);
      default: send_byte(CH_SPACE);
    endcase
  endtask

  task automatic test_directed();
    send_text("(+-*/;)");
    send_byte(CH_TAB);
    send_text(".5.x");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("print 7.");
    send_byte(8'hFF);
    send_text("true//#");
    send_byte(CH_NUL);
    send_text("false");
    send_byte(CH_NUL);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    repeat (48) send_byte(CH_LPAR);
    send_text("ab+");
    wait_drained();
  endtask

  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = sent_cnt + n_bytes;
    while (sent_cnt < stop_at) send_fragment();
    send_byte(CH_NUL);
  endtask

  initial begin
    push       = 1'b0;
    in_char_in = CH_NUL;
    rst_n      = 1'b0;
    clear_scanner();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 58;
    test_directed();
    test_backpressure();
    test_random_text(RANDOM_BYTES);

    send_idle_pct = 58;
    recv_idle_pct = 32;
    test_random_text(RANDOM_BYTES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(RANDOM_BYTES);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Streamed %0d text bytes and checked %0d tokens", sent_cnt, checked_cnt);
    $display("over directed, stalled and random texts.");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/elt_pkg.sv
src/elt_scan.sv
src/elt_tokq.sv
src/expression_language_tokenizer.sv
tb/sv/tb_expression_language_tokenizer.sv
